// ===== rtl/csel_pkg.sv =====
// ----------------------------------------------------------------------------
// csel_pkg
// Shared types and constants for the CSR sparse matrix entry lookup.
// ----------------------------------------------------------------------------
package csel_pkg;

  localparam int MAX_ROWS     = 1024;
  localparam int MAX_NONZEROS = 4096;
  localparam int COL_BITS     = 16;
  localparam int VALUE_WIDTH  = 32;

  localparam int ROW_W   = 11;
  localparam int PTR_W   = 13;
  localparam int POS_W   = 12;
  localparam int ROW_AW  = $clog2(MAX_ROWS + 1);
  localparam int NZ_AW   = $clog2(MAX_NONZEROS);
  localparam int NROWS_W = 11;
  localparam int NCOLS_W = 17;
  localparam int CFG_W   = 17;

  localparam logic [1:0] REQ_ROW_PTR = 2'd0;
  localparam logic [1:0] REQ_NONZERO = 2'd1;
  localparam logic [1:0] REQ_LOOKUP  = 2'd2;

  localparam logic CFG_NUM_ROWS = 1'b0;
  localparam logic CFG_NUM_COLS = 1'b1;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [ROW_W-1:0]       row;
    logic [COL_BITS-1:0]    col;
    logic [PTR_W-1:0]       position;
    logic [VALUE_WIDTH-1:0] value;
  } req_t;

  typedef struct packed {
    logic                   found;
    logic [VALUE_WIDTH-1:0] entry_value;
    logic [POS_W-1:0]       entry_position;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ROW_AW-1:0] waddr;
    logic [PTR_W-1:0]  wdata;
    logic              re;
    logic [ROW_AW-1:0] raddr;
  } row_mem_ctl_t;

  typedef struct packed {
    logic                   we;
    logic [NZ_AW-1:0]       waddr;
    logic [COL_BITS-1:0]    col;
    logic [VALUE_WIDTH-1:0] value;
    logic                   re;
    logic [NZ_AW-1:0]       raddr;
  } nz_mem_ctl_t;

endpackage

// ===== rtl/csel_ram.sv =====
// ----------------------------------------------------------------------------
// csel_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module csel_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/csel_ctrl.sv =====
// ----------------------------------------------------------------------------
// csel_ctrl
// Request decode, size registers and binary search sequencer.
// ----------------------------------------------------------------------------
module csel_ctrl
  import csel_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  req_t                   req,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output rsp_t                   rsp,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  output row_mem_ctl_t           row_ctl,
  input  logic [PTR_W-1:0]       row_rdata,
  output nz_mem_ctl_t            nz_ctl,
  input  logic [COL_BITS-1:0]    col_rdata,
  input  logic [VALUE_WIDTH-1:0] val_rdata
);

  typedef enum logic [2:0] {
    IDLE,
    RD_LO,
    RD_HI,
    PROBE,
    FINISH
  } state_t;

  state_t                 state;
  logic [NROWS_W-1:0]     num_rows;
  logic [NCOLS_W-1:0]     num_cols;
  logic [ROW_W-1:0]       row_q;
  logic [COL_BITS-1:0]    col_q;
  logic [PTR_W-1:0]       lo;
  logic [PTR_W-1:0]       hi;
  logic [NZ_AW-1:0]       mid;
  rsp_t                   res;

  logic                   accept;
  logic                   miss;
  logic                   hit;
  logic [PTR_W-1:0]       hi_clamp;
  logic [PTR_W-1:0]       range_lo;
  logic [PTR_W-1:0]       range_hi;
  logic                   range_ok;
  logic [PTR_W-1:0]       mid_calc;
  logic [NZ_AW-1:0]       mid_next;

  assign req_ready = (state == IDLE);
  assign accept    = req_valid && req_ready;

  assign miss = (req.row >= num_rows) || (req.row >= ROW_W'(MAX_ROWS)) ||
                ({1'b0, req.col} >= num_cols);

  assign hit = (col_rdata == col_q);

  assign hi_clamp = (row_rdata > PTR_W'(MAX_NONZEROS)) ? PTR_W'(MAX_NONZEROS) : row_rdata;

  always_comb begin
    range_lo = lo;
    range_hi = hi;
    if (state == RD_HI) begin
      range_hi = hi_clamp;
    end else if (col_rdata < col_q) begin
      range_lo = PTR_W'({1'b0, mid}) + PTR_W'(1);
    end else begin
      range_hi = PTR_W'({1'b0, mid});
    end
  end

  assign range_ok = (range_lo < range_hi);
  assign mid_calc = range_lo + ((range_hi - range_lo) >> 1);
  assign mid_next = mid_calc[NZ_AW-1:0];

  always_comb begin
    row_ctl.we    = accept && (req.req_type == REQ_ROW_PTR) &&
                    (req.row <= ROW_W'(MAX_ROWS));
    row_ctl.waddr = ROW_AW'(req.row);
    row_ctl.wdata = req.position;
    row_ctl.re    = (accept && (req.req_type == REQ_LOOKUP) && !miss) || (state == RD_LO);
    row_ctl.raddr = (state == RD_LO) ? ROW_AW'(row_q + ROW_W'(1)) : ROW_AW'(req.row);

    nz_ctl.we    = accept && (req.req_type == REQ_NONZERO) &&
                   (req.position < PTR_W'(MAX_NONZEROS));
    nz_ctl.waddr = req.position[NZ_AW-1:0];
    nz_ctl.col   = req.col;
    nz_ctl.value = req.value;
    nz_ctl.re    = ((state == RD_HI) || ((state == PROBE) && !hit)) && range_ok;
    nz_ctl.raddr = mid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= '0;
      num_cols <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_ROWS: num_rows <= cfg_wdata[NROWS_W-1:0];
        CFG_NUM_COLS: num_cols <= cfg_wdata[NCOLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != FINISH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept && (req.req_type == REQ_LOOKUP)) begin
            row_q <= req.row;
            col_q <= req.col;
            if (miss) begin
              res   <= '0;
              state <= FINISH;
            end else begin
              state <= RD_LO;
            end
          end
        end
        RD_LO: begin
          lo    <= row_rdata;
          state <= RD_HI;
        end
        RD_HI: begin
          lo <= range_lo;
          hi <= range_hi;
          if (range_ok) begin
            mid   <= mid_next;
            state <= PROBE;
          end else begin
            res   <= '0;
            state <= FINISH;
          end
        end
        PROBE: begin
          if (hit) begin
            res.found          <= 1'b1;
            res.entry_value    <= val_rdata;
            res.entry_position <= mid;
            state              <= FINISH;
          end else begin
            lo <= range_lo;
            hi <= range_hi;
            if (range_ok) begin
              mid <= mid_next;
            end else begin
              res   <= '0;
              state <= FINISH;
            end
          end
        end
        FINISH: begin
          if (!rsp_valid || rsp_ready) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/csr_sparse_entry_lookup.sv =====
// ----------------------------------------------------------------------------
// csr_sparse_entry_lookup
// Element lookup in a sparse matrix held in compressed-sparse-row form.
// ----------------------------------------------------------------------------
//  channel | signals                    | moves
//  --------+----------------------------+-----------------------------------
//  req     | req_valid/req_ready, req   | row ptr write, nonzero write, lookup
//  rsp     | rsp_valid/rsp_ready, rsp   | one result per lookup request
//  cfg     | cfg_we, cfg_index, cfg_wdata | num_rows, num_cols
//
//  Write requests complete on acceptance. A lookup runs P binary search
//  probes (at most 13), each one column store read; an early range miss
//  skips the search. Row bounds come from two row pointer reads.
//  Reset clears control and size registers; stores are undefined until written.
//  A stalled result waits in the output register while writes keep flowing.
// ----------------------------------------------------------------------------
module csr_sparse_entry_lookup
  import csel_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  row_mem_ctl_t           row_ctl;
  nz_mem_ctl_t            nz_ctl;
  logic [PTR_W-1:0]       row_rdata;
  logic [COL_BITS-1:0]    col_rdata;
  logic [VALUE_WIDTH-1:0] val_rdata;

  csel_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .row_ctl   (row_ctl),
    .row_rdata (row_rdata),
    .nz_ctl    (nz_ctl),
    .col_rdata (col_rdata),
    .val_rdata (val_rdata)
  );

  csel_ram #(
    .WIDTH (PTR_W),
    .DEPTH (MAX_ROWS + 1)
  ) u_row_start (
    .clk   (clk),
    .we    (row_ctl.we),
    .waddr (row_ctl.waddr),
    .wdata (row_ctl.wdata),
    .re    (row_ctl.re),
    .raddr (row_ctl.raddr),
    .rdata (row_rdata)
  );

  csel_ram #(
    .WIDTH (COL_BITS),
    .DEPTH (MAX_NONZEROS)
  ) u_column (
    .clk   (clk),
    .we    (nz_ctl.we),
    .waddr (nz_ctl.waddr),
    .wdata (nz_ctl.col),
    .re    (nz_ctl.re),
    .raddr (nz_ctl.raddr),
    .rdata (col_rdata)
  );

  csel_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_NONZEROS)
  ) u_value (
    .clk   (clk),
    .we    (nz_ctl.we),
    .waddr (nz_ctl.waddr),
    .wdata (nz_ctl.value),
    .re    (nz_ctl.re),
    .raddr (nz_ctl.raddr),
    .rdata (val_rdata)
  );

endmodule

// ===== sim/csel_lookup_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// csel_lookup_checker
// Watches the request, result and size-write ports of the CSR entry lookup.
// Mirrors the row pointer, column and value stores and the matrix size.
// Predicts each lookup's result when the request is accepted and compares
// results in order.
// ----------------------------------------------------------------------------
module csel_lookup_checker
  import csel_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_ready,
  input  req_t             req,
  input  logic             rsp_valid,
  input  logic             rsp_ready,
  input  rsp_t             rsp,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               errors,
  output int               pending
);

  logic [PTR_W-1:0]       row_start_m [0:MAX_ROWS];
  logic [COL_BITS-1:0]    col_m       [0:MAX_NONZEROS-1];
  logic [VALUE_WIDTH-1:0] val_m       [0:MAX_NONZEROS-1];
  logic [NROWS_W-1:0]     num_rows_m;
  logic [NCOLS_W-1:0]     num_cols_m;
  rsp_t                   expected_entries [$];

  function automatic rsp_t search_entry(input req_t r);
    rsp_t res;
    int   lo;
    int   hi;
    int   mid;
    res = '0;
    if (r.row >= num_rows_m || r.row >= MAX_ROWS || r.col >= num_cols_m) return res;
    lo = row_start_m[r.row];
    hi = row_start_m[int'(r.row) + 1];
    if (hi > MAX_NONZEROS) hi = MAX_NONZEROS;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (col_m[mid] == r.col) begin
        res.found          = 1'b1;
        res.entry_value    = val_m[mid];
        res.entry_position = mid[POS_W-1:0];
        return res;
      end
      if (col_m[mid] < r.col) lo = mid + 1;
      else hi = mid;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      expected_entries.delete();
      num_rows_m = '0;
      num_cols_m = '0;
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NUM_ROWS) num_rows_m = cfg_wdata[NROWS_W-1:0];
        else num_cols_m = cfg_wdata[NCOLS_W-1:0];
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_entries.size() == 0) begin
          $display("%0t: result with no lookup pending: found=%0d value=%h position=%0d",
                   $time, rsp.found, rsp.entry_value, rsp.entry_position);
          errors++;
        end else begin
          want = expected_entries.pop_front();
          if (rsp.found !== want.found) begin
            $display("%0t: found mismatch: expected %0d, got %0d",
                     $time, want.found, rsp.found);
            errors++;
          end
          if (rsp.entry_value !== want.entry_value) begin
            $display("%0t: entry_value mismatch: expected %h, got %h",
                     $time, want.entry_value, rsp.entry_value);
            errors++;
          end
          if (rsp.entry_position !== want.entry_position) begin
            $display("%0t: entry_position mismatch: expected %0d, got %0d",
                     $time, want.entry_position, rsp.entry_position);
            errors++;
          end
        end
      end
      if (req_valid && req_ready) begin
        case (req.req_type)
          REQ_ROW_PTR: if (req.row <= MAX_ROWS) row_start_m[req.row] = req.position;
          REQ_NONZERO: begin
            if (req.position < MAX_NONZEROS) begin
              col_m[req.position] = req.col;
              val_m[req.position] = req.value;
            end
          end
          REQ_LOOKUP: expected_entries.push_back(search_entry(req));
          default: ;
        endcase
      end
    end
    pending <= expected_entries.size();
  end

endmodule

// ===== sim/tb_csr_sparse_entry_lookup.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_csr_sparse_entry_lookup
// Loads small CSR matrices into the block and looks up hits, near misses,
// range misses, empty and clamped rows, with random idle on both channels.
// Only lookups that touch written store entries are issued. The checker
// predicts and compares results; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_csr_sparse_entry_lookup;
  import csel_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int ITEMS = 1050;
  localparam int DRAIN_CYCLES = 24;
  localparam int LIMIT = 500000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  req_t             req = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_NUM_ROWS;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int               errors;
  int               pending;

  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int sent = 0;
  int cycles = 0;
  int rows_sh = 0;
  int cols_sh = 0;

  logic [PTR_W-1:0]    rp_sh  [0:MAX_ROWS];
  bit                  rp_ok  [0:MAX_ROWS];
  logic [COL_BITS-1:0] col_sh [0:MAX_NONZEROS-1];
  bit                  col_ok [0:MAX_NONZEROS-1];

  csr_sparse_entry_lookup dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  csel_lookup_checker chk (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic req_t mk_req(input logic [1:0] kind, input int row, input int col,
                                  input int pos, input logic [31:0] val);
    req_t r;
    r.req_type = kind;
    r.row      = row[ROW_W-1:0];
    r.col      = col[COL_BITS-1:0];
    r.position = pos[PTR_W-1:0];
    r.value    = val;
    return r;
  endfunction

  // requests the block must ignore
  function automatic req_t noise_req();
    case ($urandom_range(2))
      0: return mk_req(REQ_UNUSED, $urandom_range(2047), $urandom_range(65535),
                       $urandom_range(8191), $urandom);
      1: return mk_req(REQ_ROW_PTR, $urandom_range(2047, MAX_ROWS + 1), 0,
                       $urandom_range(8191), $urandom);
      default: return mk_req(REQ_NONZERO, 0, $urandom_range(65535),
                             $urandom_range(8191, MAX_NONZEROS), $urandom);
    endcase
  endfunction

  // true when a lookup reads only store entries already written
  function automatic bit reads_written(input int row, input int col);
    int lo;
    int hi;
    int mid;
    if (row >= rows_sh || row >= MAX_ROWS || col >= cols_sh) return 1'b1;
    if (!rp_ok[row] || !rp_ok[row + 1]) return 1'b0;
    lo = rp_sh[row];
    hi = rp_sh[row + 1];
    if (hi > MAX_NONZEROS) hi = MAX_NONZEROS;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (!col_ok[mid]) return 1'b0;
      if (col_sh[mid] == col) return 1'b1;
      if (col_sh[mid] < col) lo = mid + 1;
      else hi = mid;
    end
    return 1'b1;
  endfunction

  task automatic send_req(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    case (r.req_type)
      REQ_ROW_PTR: begin
        if (r.row <= MAX_ROWS) begin
          rp_sh[r.row] = r.position;
          rp_ok[r.row] = 1'b1;
          sent++;
        end
      end
      REQ_NONZERO: begin
        if (r.position < MAX_NONZEROS) begin
          col_sh[r.position] = r.col;
          col_ok[r.position] = 1'b1;
          sent++;
        end
      end
      REQ_LOOKUP: sent++;
      default: ;
    endcase
  endtask

  task automatic look_up(input int row, input int col);
    if (!reads_written(row, col)) row = $urandom_range(2047, MAX_ROWS);
    send_req(mk_req(REQ_LOOKUP, row, col, $urandom_range(8191), $urandom));
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input int nrows, input int ncols);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NUM_ROWS;
    cfg_wdata <= CFG_W'(nrows);
    @(posedge clk);
    cfg_index <= CFG_NUM_COLS;
    cfg_wdata <= CFG_W'(ncols);
    @(posedge clk);
    cfg_we <= 1'b0;
    rows_sh = nrows;
    cols_sh = ncols;
  endtask

  initial begin : stim
    req_t batch [$];
    req_t tmp;
    int   hit_row [$];
    int   hit_col [$];
    int   ks [0:63];
    int   phase;
    int   nr;
    int   r0;
    int   b0;
    int   total;
    int   slot;
    int   span;
    int   step;
    int   c;
    int   i;
    int   j;
    int   nl;
    int   sel;
    bit   scram;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_size(MAX_ROWS, 65536);
    send_req(mk_req(REQ_ROW_PTR, 0, 0, 0, 0));
    send_req(mk_req(REQ_ROW_PTR, 1, 0, 3, 0));
    send_req(mk_req(REQ_ROW_PTR, 2, 0, 3, 0));
    send_req(mk_req(REQ_NONZERO, 0, 0, 0, 32'h0));
    send_req(mk_req(REQ_NONZERO, 0, 1000, 1, 32'hFFFF_FFFF));
    send_req(mk_req(REQ_NONZERO, 0, 65535, 2, 32'h1234_5678));
    look_up(0, 0);
    look_up(0, 1000);
    look_up(0, 65535);
    look_up(0, 500);
    look_up(1, 7);
    // last row, end pointer past the store gets clamped
    send_req(mk_req(REQ_ROW_PTR, 1023, 0, 4094, 0));
    send_req(mk_req(REQ_ROW_PTR, MAX_ROWS, 0, 8191, 0));
    send_req(mk_req(REQ_NONZERO, 0, 7, 4094, 32'hA5A5_A5A5));
    send_req(mk_req(REQ_NONZERO, 0, 9, 4095, 32'h5A5A_5A5A));
    look_up(1023, 9);
    look_up(1023, 8);
    send_req(mk_req(REQ_ROW_PTR, 2047, 0, 0, 0));
    send_req(mk_req(REQ_NONZERO, 0, 0, 8191, 32'hDEAD_BEEF));
    send_req(mk_req(REQ_UNUSED, 5, 5, 5, 32'h5));
    look_up(MAX_ROWS, 0);
    look_up(2047, 65535);
    // start above end: empty row
    send_req(mk_req(REQ_ROW_PTR, 5, 0, 10, 0));
    send_req(mk_req(REQ_ROW_PTR, 6, 0, 5, 0));
    look_up(5, 3);
    set_size(1, 1);
    look_up(0, 0);
    look_up(0, 1);
    set_size(0, 0);
    look_up(0, 0);

    phase = 0;
    while (sent < ITEMS) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
        1: begin send_idle_pct = 67; rsp_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  rsp_stall_pct = 67; end
        default: begin send_idle_pct = 34; rsp_stall_pct = 34; end
      endcase
      phase++;

      nr = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      r0 = $urandom_range(MAX_ROWS - nr);
      total = 0;
      for (i = 0; i < nr; i++) begin
        ks[i] = $urandom_range(6);
        total += ks[i];
      end
      b0 = ($urandom_range(3) == 0) ? MAX_NONZEROS - total
                                    : $urandom_range(MAX_NONZEROS - total);

      case ($urandom_range(7))
        0: nl = 0;
        1: nl = MAX_ROWS;
        2: nl = 2047;
        3: nl = $urandom_range(MAX_ROWS);
        default: nl = r0 + nr;
      endcase
      case ($urandom_range(7))
        0: c = 0;
        2: c = $urandom_range(1, 64);
        3: c = $urandom_range(65536);
        default: c = 65536;
      endcase
      set_size(nl, c);
      span = (cols_sh == 0) ? 65536 : cols_sh;
      scram = ($urandom_range(5) == 0);

      batch.delete();
      hit_row.delete();
      hit_col.delete();
      slot = b0;
      for (i = 0; i < nr; i++) begin
        batch.push_back(mk_req(REQ_ROW_PTR, r0 + i, 0, slot, 0));
        step = span / (ks[i] + 1);
        if (step < 1) step = 1;
        c = -1;
        for (j = 0; j < ks[i]; j++) begin
          c = scram ? $urandom_range(span - 1) : c + $urandom_range(1, step);
          batch.push_back(mk_req(REQ_NONZERO, 0, c, slot, $urandom));
          hit_row.push_back(r0 + i);
          hit_col.push_back(c);
          slot++;
        end
      end
      if (slot == MAX_NONZEROS && $urandom_range(1) == 1)
        batch.push_back(mk_req(REQ_ROW_PTR, r0 + nr, 0, $urandom_range(8191, slot), 0));
      else
        batch.push_back(mk_req(REQ_ROW_PTR, r0 + nr, 0, slot, 0));
      for (i = $urandom_range(2); i > 0; i--) batch.push_back(noise_req());

      for (i = batch.size() - 1; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = batch[i];
        batch[i] = batch[j];
        batch[j] = tmp;
      end
      foreach (batch[k]) send_req(batch[k]);

      nl = $urandom_range(15, 40);
      for (i = 0; i < nl; i++) begin
        sel = $urandom_range(9);
        if (sel < 6 && hit_row.size() > 0) begin
          j = $urandom_range(hit_row.size() - 1);
          look_up(hit_row[j], hit_col[j]);
        end else if (sel == 6 && hit_row.size() > 0) begin
          j = $urandom_range(hit_row.size() - 1);
          c = hit_col[j] + ($urandom_range(1) ? 1 : -1);
          if (c < 0) c = 0;
          if (c > 65535) c = 65535;
          look_up(hit_row[j], c);
        end else if (sel == 7) begin
          look_up(r0 + $urandom_range(nr), $urandom_range(65535));
        end else if (sel == 8) begin
          send_req(noise_req());
        end else begin
          look_up($urandom_range(2047), $urandom_range(65535));
        end
      end
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
